@@ hdl/tgfr_pkg.sv @@
// Shared types, constants and the 5x7 font table for the text glyph renderer.
`timescale 1ns / 1ps

package tgfr_pkg;

  // Default panel geometry
  localparam int WIDTH_PX_DEF  = 128;
  localparam int HEIGHT_PX_DEF = 32;

  // Glyph cell
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;

  // One glyph: five columns, bit 0 is the top row
  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

  // Request codes
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Pack five column bytes, leftmost column first
  function automatic glyph_t g5(input logic [7:0] c0, input logic [7:0] c1,
                                input logic [7:0] c2, input logic [7:0] c3,
                                input logic [7:0] c4);
    glyph_t g;
    g[0] = c0[6:0];
    g[1] = c1[6:0];
    g[2] = c2[6:0];
    g[3] = c3[6:0];
    g[4] = c4[6:0];
    return g;
  endfunction

  // Font lookup; lowercase folds to uppercase, anything unknown is blank
  function automatic glyph_t font_glyph(input logic [7:0] code);
    logic [7:0] c;
    glyph_t     g;
    c = code;
    if (code >= 8'h61 && code <= 8'h7a) begin
      c = code - 8'd32;
    end
    case (c)
      8'h21: g = g5(8'h00, 8'h00, 8'h5f, 8'h00, 8'h00); // !
      8'h23: g = g5(8'h14, 8'h7f, 8'h14, 8'h7f, 8'h14); // #
      8'h25: g = g5(8'h23, 8'h13, 8'h08, 8'h64, 8'h62); // %
      8'h28: g = g5(8'h00, 8'h1c, 8'h22, 8'h41, 8'h00); // (
      8'h29: g = g5(8'h00, 8'h41, 8'h22, 8'h1c, 8'h00); // )
      8'h2a: g = g5(8'h14, 8'h08, 8'h3e, 8'h08, 8'h14); // *
      8'h2b: g = g5(8'h08, 8'h08, 8'h3e, 8'h08, 8'h08); // +
      8'h2c: g = g5(8'h00, 8'h50, 8'h30, 8'h00, 8'h00); // ,
      8'h2d: g = g5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08); // -
      8'h2e: g = g5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00); // .
      8'h2f: g = g5(8'h20, 8'h10, 8'h08, 8'h04, 8'h02); // /
      8'h30: g = g5(8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e); // 0
      8'h31: g = g5(8'h00, 8'h42, 8'h7f, 8'h40, 8'h00); // 1
      8'h32: g = g5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46); // 2
      8'h33: g = g5(8'h21, 8'h41, 8'h45, 8'h4b, 8'h31); // 3
      8'h34: g = g5(8'h18, 8'h14, 8'h12, 8'h7f, 8'h10); // 4
      8'h35: g = g5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39); // 5
      8'h36: g = g5(8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30); // 6
      8'h37: g = g5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03); // 7
      8'h38: g = g5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36); // 8
      8'h39: g = g5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1e); // 9
      8'h3a: g = g5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00); // :
      8'h3c: g = g5(8'h08, 8'h14, 8'h22, 8'h41, 8'h00); // <
      8'h3d: g = g5(8'h14, 8'h14, 8'h14, 8'h14, 8'h14); // =
      8'h3e: g = g5(8'h41, 8'h22, 8'h14, 8'h08, 8'h00); // >
      8'h3f: g = g5(8'h02, 8'h01, 8'h51, 8'h09, 8'h06); // ?
      8'h41: g = g5(8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e); // A
      8'h42: g = g5(8'h7f, 8'h49, 8'h49, 8'h49, 8'h36); // B
      8'h43: g = g5(8'h3e, 8'h41, 8'h41, 8'h41, 8'h22); // C
      8'h44: g = g5(8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c); // D
      8'h45: g = g5(8'h7f, 8'h49, 8'h49, 8'h49, 8'h41); // E
      8'h46: g = g5(8'h7f, 8'h09, 8'h09, 8'h01, 8'h01); // F
      8'h47: g = g5(8'h3e, 8'h41, 8'h41, 8'h51, 8'h32); // G
      8'h48: g = g5(8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f); // H
      8'h49: g = g5(8'h00, 8'h41, 8'h7f, 8'h41, 8'h00); // I
      8'h4a: g = g5(8'h20, 8'h40, 8'h41, 8'h3f, 8'h01); // J
      8'h4b: g = g5(8'h7f, 8'h08, 8'h14, 8'h22, 8'h41); // K
      8'h4c: g = g5(8'h7f, 8'h40, 8'h40, 8'h40, 8'h40); // L
      8'h4d: g = g5(8'h7f, 8'h02, 8'h04, 8'h02, 8'h7f); // M
      8'h4e: g = g5(8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f); // N
      8'h4f: g = g5(8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e); // O
      8'h50: g = g5(8'h7f, 8'h09, 8'h09, 8'h09, 8'h06); // P
      8'h51: g = g5(8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e); // Q
      8'h52: g = g5(8'h7f, 8'h09, 8'h19, 8'h29, 8'h46); // R
      8'h53: g = g5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31); // S
      8'h54: g = g5(8'h01, 8'h01, 8'h7f, 8'h01, 8'h01); // T
      8'h55: g = g5(8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f); // U
      8'h56: g = g5(8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f); // V
      8'h57: g = g5(8'h7f, 8'h20, 8'h18, 8'h20, 8'h7f); // W
      8'h58: g = g5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63); // X
      8'h59: g = g5(8'h03, 8'h04, 8'h78, 8'h04, 8'h03); // Y
      8'h5a: g = g5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43); // Z
      8'h5f: g = g5(8'h40, 8'h40, 8'h40, 8'h40, 8'h40); // _
      default: g = '0;                                 // space and unknown
    endcase
    return g;
  endfunction

endpackage

@@ hdl/tgfr_frame_mem.sv @@
// Framebuffer store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module tgfr_frame_mem #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/tgfr_slot_gen.sv @@
// Maps one draw slot (glyph column, upper or lower page) to a byte address and OR mask.
`timescale 1ns / 1ps

module tgfr_slot_gen #(
  parameter int WIDTH_PX  = 128,
  parameter int HEIGHT_PX = 32,
  parameter int ADDR_W    = 9
) (
  input  logic signed [8:0]    x_pos,
  input  logic signed [7:0]    y_pos,
  input  tgfr_pkg::glyph_t     glyph,
  input  logic [3:0]           slot,
  output logic                 slot_ok,
  output logic [ADDR_W-1:0]    slot_addr,
  output logic [7:0]           slot_bits
);

  localparam int PAGES = (HEIGHT_PX + 7) / 8;
  localparam logic [8:0] X_LIM = 9'(WIDTH_PX);
  localparam logic [4:0] P_LIM = 5'(PAGES);
  localparam logic [4:0] P_LAST = 5'(PAGES - 1);
  localparam logic [7:0] LAST_MASK = 8'((1 << (HEIGHT_PX - 8 * (PAGES - 1))) - 1);

  logic [2:0]  col;
  logic        half;
  logic [9:0]  col_x;
  logic [5:0]  page;
  logic        x_ok;
  logic        p_ok;
  logic [15:0] shifted;
  logic [7:0]  bits_raw;

  assign col  = slot[3:1];
  assign half = slot[0];

  // Column position and page, both two's complement
  assign col_x = {x_pos[8], x_pos} + {7'b0, col};
  assign page  = {y_pos[7], y_pos[7:3]} + {5'b0, half};

  assign x_ok = !col_x[9] && (col_x[8:0] < X_LIM);
  assign p_ok = !page[5] && (page[4:0] < P_LIM);

  // Glyph column shifted into the page pair by the row offset
  assign shifted  = {9'b0, glyph[col]} << y_pos[2:0];
  assign bits_raw = half ? shifted[15:8] : shifted[7:0];

  // Rows below the panel bottom in a partial last page are dropped
  assign slot_bits = (page[4:0] == P_LAST) ? (bits_raw & LAST_MASK) : bits_raw;
  assign slot_ok   = x_ok && p_ok;
  assign slot_addr = ADDR_W'(page[4:0]) * ADDR_W'(WIDTH_PX) + ADDR_W'(col_x[8:0]);

endmodule

@@ hdl/text_glyph_framebuffer_renderer.sv @@
// Top level: request sequencer around the framebuffer store and font lookup.
`timescale 1ns / 1ps

// Page-organized monochrome framebuffer (WIDTH_PX x HEIGHT_PX, byte = page*WIDTH_PX
// + column, bit 0 on top) with a built-in 5x7 font. A request is taken when start
// is high and busy is low; every request yields exactly one out_valid pulse, one
// cycle wide, which the receiver cannot hold off. A draw walks ten slots (five
// columns, two pages each) through a pipelined read-modify-write on the store's
// single write and read port and then returns its beat. A read returns its byte
// through the READ and RDATA states (out of range reads and request type 3 return
// zero straight from idle). A clear sweeps one byte per cycle and then returns its
// beat. After reset the same sweep runs (busy high) and produces no beat.
module text_glyph_framebuffer_renderer #(
  parameter int WIDTH_PX  = tgfr_pkg::WIDTH_PX_DEF,
  parameter int HEIGHT_PX = tgfr_pkg::HEIGHT_PX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_char_code,
  input  logic signed [8:0] in_x_pos,
  input  logic signed [7:0] in_y_pos,
  input  logic [8:0]        in_read_index,
  output logic              out_valid,
  output logic [7:0]        out_read_data
);

  localparam int PAGES  = (HEIGHT_PX + 7) / 8;
  localparam int DEPTH  = WIDTH_PX * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [11:0] DEPTH_LIM = 12'(DEPTH);
  localparam logic [3:0]  LAST_SLOT = 4'(2 * tgfr_pkg::GLYPH_COLS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_DRAIN,
    ST_READ,
    ST_RDATA
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               clr_req_r, clr_req_nxt;
  logic [3:0]         slot_r, slot_nxt;
  tgfr_pkg::glyph_t   glyph_r, glyph_nxt;
  logic signed [8:0]  x_r, x_nxt;
  logic signed [7:0]  y_r, y_nxt;
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic               pend_ok_r, pend_ok_nxt;
  logic [ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic [7:0]         pend_bits_r, pend_bits_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;

  logic               slot_ok;
  logic [ADDR_W-1:0]  slot_addr;
  logic [7:0]         slot_bits;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [7:0]         mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [7:0]         mem_rdata;

  tgfr_slot_gen #(
    .WIDTH_PX  (WIDTH_PX),
    .HEIGHT_PX (HEIGHT_PX),
    .ADDR_W    (ADDR_W)
  ) u_slot_gen (
    .x_pos     (x_r),
    .y_pos     (y_r),
    .glyph     (glyph_r),
    .slot      (slot_r),
    .slot_ok   (slot_ok),
    .slot_addr (slot_addr),
    .slot_bits (slot_bits)
  );

  tgfr_frame_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Store port steering: clear sweep, or write-back of the pending slot
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = 8'h00;
    end else begin
      mem_we    = pend_ok_r;
      mem_waddr = pend_addr_r;
      mem_wdata = mem_rdata | pend_bits_r;
    end
    mem_raddr = (state_r == ST_DRAW) ? slot_addr : rd_addr_r;
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_req_nxt   = clr_req_r;
    slot_nxt      = slot_r;
    glyph_nxt     = glyph_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    rd_addr_nxt   = rd_addr_r;
    pend_ok_nxt   = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pend_bits_nxt = pend_bits_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = 8'h00;

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = clr_req_r;
          clr_req_nxt   = 1'b0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (tgfr_pkg::req_t'(in_req_type))
            tgfr_pkg::REQ_CLEAR: begin
              state_nxt   = ST_CLEAR;
              clr_cnt_nxt = '0;
              clr_req_nxt = 1'b1;
            end
            tgfr_pkg::REQ_DRAW: begin
              state_nxt = ST_DRAW;
              slot_nxt  = '0;
              glyph_nxt = tgfr_pkg::font_glyph(in_char_code);
              x_nxt     = in_x_pos;
              y_nxt     = in_y_pos;
            end
            tgfr_pkg::REQ_READ: begin
              if ({3'b0, in_read_index} < DEPTH_LIM) begin
                state_nxt   = ST_READ;
                rd_addr_nxt = ADDR_W'(in_read_index);
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      // Read slot now, write it back next cycle
      ST_DRAW: begin
        pend_ok_nxt   = slot_ok;
        pend_addr_nxt = slot_addr;
        pend_bits_nxt = slot_bits;
        slot_nxt      = slot_r + 1'b1;
        if (slot_r == LAST_SLOT) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      ST_READ: begin
        state_nxt = ST_RDATA;
      end
      ST_RDATA: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt  = mem_rdata;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_req_r   <= 1'b0;
      pend_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_req_r   <= clr_req_nxt;
      pend_ok_r   <= pend_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    glyph_r     <= glyph_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    rd_addr_r   <= rd_addr_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_bits_r <= pend_bits_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule
